// ===== design/chrup_pkg.sv =====
// ----------------------------------------------------------------------------
// chrup_pkg
// Types and constants shared by the chroma upsample row filter.
// ----------------------------------------------------------------------------
package chrup_pkg;

    localparam int RESID_W = 16;
    localparam int PIX_W   = 14;
    localparam int DEPTH_W = 4;
    localparam int SUM_W   = 20;
    localparam int FRAC_SHIFT = 4;

    typedef logic signed [RESID_W-1:0] t_resid;
    typedef logic        [PIX_W-1:0]   t_pix;
    typedef logic        [DEPTH_W-1:0] t_depth;

    localparam t_depth BIT_DEPTH_RESET = t_depth'(8);
    localparam t_depth BIT_DEPTH_MIN   = t_depth'(8);
    localparam t_depth BIT_DEPTH_MAX   = t_depth'(14);
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'(8);

    typedef struct packed {
        t_resid a0;
        t_resid b0;
        t_resid a1;
        t_resid b1;
        t_pix   base_even;
        t_pix   base_odd;
    } t_column;

endpackage

// ===== design/chrup_in_if.sv =====
// ----------------------------------------------------------------------------
// chrup_in_if
// Input channel: one residual column with its base samples per transaction.
// ----------------------------------------------------------------------------
interface chrup_in_if;
    import chrup_pkg::*;

    logic   valid;
    logic   ready;
    t_resid near_next;
    t_resid far_next;
    t_pix   base_even;
    t_pix   base_odd;
    logic   row_start;

    modport source (
        output valid, near_next, far_next, base_even, base_odd, row_start,
        input  ready
    );
    modport sink (
        input  valid, near_next, far_next, base_even, base_odd, row_start,
        output ready
    );
endinterface

// ===== design/chrup_out_if.sv =====
// ----------------------------------------------------------------------------
// chrup_out_if
// Output channel: one pair of upsampled, clipped samples per transaction.
// ----------------------------------------------------------------------------
interface chrup_out_if;
    import chrup_pkg::*;

    logic valid;
    logic ready;
    t_pix out_even;
    t_pix out_odd;

    modport source (output valid, out_even, out_odd, input ready);
    modport sink   (input  valid, out_even, out_odd, output ready);
endinterface

// ===== design/chrup_filter.sv =====
// ----------------------------------------------------------------------------
// chrup_filter
// 9-3-3-1 weighted sum, rounding shift, base add and clip for one column pair.
// ----------------------------------------------------------------------------
module chrup_filter (
    input  chrup_pkg::t_column i_col,
    input  chrup_pkg::t_depth  i_bit_depth,
    output chrup_pkg::t_pix    o_out_even,
    output chrup_pkg::t_pix    o_out_odd
);
    import chrup_pkg::*;

    localparam int SUM_OUT_W = PIX_W + 4;

    logic signed [SUM_W-1:0]     a0_x;
    logic signed [SUM_W-1:0]     b0_x;
    logic signed [SUM_W-1:0]     a1_x;
    logic signed [SUM_W-1:0]     b1_x;
    logic signed [SUM_W-1:0]     sum_even;
    logic signed [SUM_W-1:0]     sum_odd;
    logic signed [RESID_W-1:0]   v_even;
    logic signed [RESID_W-1:0]   v_odd;
    logic signed [SUM_OUT_W-1:0] t_even;
    logic signed [SUM_OUT_W-1:0] t_odd;
    logic signed [SUM_OUT_W-1:0] max_val;
    t_depth                      depth;

    function automatic t_pix clip(input logic signed [SUM_OUT_W-1:0] v,
                                  input logic signed [SUM_OUT_W-1:0] maxv);
        t_pix r;
        if (v < 0) begin
            r = '0;
        end else if (v > maxv) begin
            r = maxv[PIX_W-1:0];
        end else begin
            r = v[PIX_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        a0_x = SUM_W'(i_col.a0);
        b0_x = SUM_W'(i_col.b0);
        a1_x = SUM_W'(i_col.a1);
        b1_x = SUM_W'(i_col.b1);

        sum_even = (a0_x <<< 3) + a0_x + (a1_x <<< 1) + a1_x
                 + (b0_x <<< 1) + b0_x + b1_x + ROUND_BIAS;
        sum_odd  = (a1_x <<< 3) + a1_x + (a0_x <<< 1) + a0_x
                 + (b1_x <<< 1) + b1_x + b0_x + ROUND_BIAS;

        v_even = sum_even[SUM_W-1:FRAC_SHIFT];
        v_odd  = sum_odd[SUM_W-1:FRAC_SHIFT];

        if (i_bit_depth < BIT_DEPTH_MIN) begin
            depth = BIT_DEPTH_MIN;
        end else if (i_bit_depth > BIT_DEPTH_MAX) begin
            depth = BIT_DEPTH_MAX;
        end else begin
            depth = i_bit_depth;
        end
        max_val = $signed({4'b0, (PIX_W'(1) << depth) - PIX_W'(1)});

        t_even = $signed({4'b0, i_col.base_even}) + SUM_OUT_W'(v_even);
        t_odd  = $signed({4'b0, i_col.base_odd})  + SUM_OUT_W'(v_odd);

        o_out_even = clip(t_even, max_val);
        o_out_odd  = clip(t_odd, max_val);
    end

endmodule

// ===== design/chroma_upsample_row_filter.sv =====
// ----------------------------------------------------------------------------
// chroma_upsample_row_filter
// 2x horizontal 9-3-3-1 upsampling of a residual row pair onto base luma.
// ----------------------------------------------------------------------------
// An accepted transaction passes the column register and then the result register on its way to o_out.
// One column per cycle while o_out.ready holds; the column register feeding the
// filter and the result register behind it hold their data under back-pressure.
// Row-start transactions only load the previous column and give no result.
// Reset clears both pipeline valids, the previous column and sets bit depth 8.
// ----------------------------------------------------------------------------
module chroma_upsample_row_filter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  chrup_pkg::t_depth i_cfg_wr_data,
    chrup_in_if.sink          i_in,
    chrup_out_if.source       o_out
);
    import chrup_pkg::*;

    t_depth  r_bit_depth, n_bit_depth;
    t_resid  r_prev_near, n_prev_near;
    t_resid  r_prev_far,  n_prev_far;
    logic    r_s1_valid,  n_s1_valid;
    t_column r_s1,        n_s1;
    logic    r_out_valid, n_out_valid;
    t_pix    r_out_even,  n_out_even;
    t_pix    r_out_odd,   n_out_odd;

    logic    in_accept;
    logic    s1_ready;
    logic    s2_ready;
    t_pix    f_even;
    t_pix    f_odd;

    chrup_filter u_filter (
        .i_col       (r_s1),
        .i_bit_depth (r_bit_depth),
        .o_out_even  (f_even),
        .o_out_odd   (f_odd)
    );

    assign s2_ready   = !r_out_valid || o_out.ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign i_in.ready = s1_ready;
    assign in_accept  = i_in.valid && s1_ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_even = r_out_even;
    assign o_out.out_odd  = r_out_odd;

    always_comb begin
        n_bit_depth = i_cfg_wr_en ? i_cfg_wr_data : r_bit_depth;
        n_prev_near = r_prev_near;
        n_prev_far  = r_prev_far;
        n_s1_valid  = r_s1_valid;
        n_s1        = r_s1;
        n_out_valid = r_out_valid;
        n_out_even  = r_out_even;
        n_out_odd   = r_out_odd;

        if (s1_ready) begin
            n_s1_valid = in_accept && !i_in.row_start;
        end
        if (in_accept) begin
            n_prev_near       = i_in.near_next;
            n_prev_far        = i_in.far_next;
            n_s1.a0           = r_prev_near;
            n_s1.b0           = r_prev_far;
            n_s1.a1           = i_in.near_next;
            n_s1.b1           = i_in.far_next;
            n_s1.base_even    = i_in.base_even;
            n_s1.base_odd     = i_in.base_odd;
        end

        if (s2_ready) begin
            n_out_valid = r_s1_valid;
            if (r_s1_valid) begin
                n_out_even = f_even;
                n_out_odd  = f_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_depth <= BIT_DEPTH_RESET;
            r_prev_near <= '0;
            r_prev_far  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_bit_depth <= n_bit_depth;
            r_prev_near <= n_prev_near;
            r_prev_far  <= n_prev_far;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1       <= n_s1;
        r_out_even <= n_out_even;
        r_out_odd  <= n_out_odd;
    end

    a_load_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_in.row_start |=> r_s1_valid && r_s1.a0 == $past(r_prev_near))
        else $error("column stage not loaded after a result transaction");

    a_keep_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_prev_near == $past(i_in.near_next)
                   && r_prev_far == $past(i_in.far_next))
        else $error("previous column not updated on transaction");

    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_ready |=> r_s1_valid && $stable(r_s1))
        else $error("column stage lost while result stalled");

    a_drop_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in.row_start |=> !r_s1_valid)
        else $error("row start transaction produced a result");

endmodule
